// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthands for clocked concurrent assertions with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== sv/idpc_pkg.sv =====
// ----------------------------------------------------------------------------
// idpc_pkg
// Types and constants shared by the implant-decay pixel correlator.
// ----------------------------------------------------------------------------
package idpc_pkg;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic       OP_IMPLANT      = 1'b0;
	localparam logic       OP_DECAY        = 1'b1;
	localparam logic [7:0] IMPLANT_QUALITY = 8'd1;
	localparam logic [7:0] DECAY_QUALITY   = 8'd5;

	// Register indexes (byte address divided by four).
	localparam logic [2:0] REG_ENERGY_X_MIN = 3'd0;
	localparam logic [2:0] REG_ENERGY_Y_MIN = 3'd1;
	localparam logic [2:0] REG_CHARGE_LOW   = 3'd2;
	localparam logic [2:0] REG_CHARGE_HIGH  = 3'd3;
	localparam logic [2:0] REG_RATIO_LOW    = 3'd4;
	localparam logic [2:0] REG_RATIO_HIGH   = 3'd5;
	localparam logic [2:0] REG_MIN_ELAPSED  = 3'd6;

	localparam logic [13:0] RST_ENERGY_X_MIN = 14'd200;
	localparam logic [13:0] RST_ENERGY_Y_MIN = 14'd200;
	localparam logic [15:0] RST_CHARGE_LOW   = 16'd6400;
	localparam logic [15:0] RST_CHARGE_HIGH  = 16'd10240;
	localparam logic [15:0] RST_RATIO_LOW    = 16'd8192;
	localparam logic [15:0] RST_RATIO_HIGH   = 16'd16384;
	localparam logic [31:0] RST_MIN_ELAPSED  = 32'd5000;

	typedef struct packed {
		logic        op;
		logic [2:0]  detector;
		logic [6:0]  strip_x;
		logic [6:0]  strip_y;
		logic [47:0] timestamp;
		logic [7:0]  quality;
		logic [15:0] charge;
		logic [15:0] mass_ratio;
		logic [13:0] energy_x;
		logic [13:0] energy_y;
	} in_item_t;

	typedef struct packed {
		logic        background;
		logic [2:0]  hit_detector;
		logic [47:0] elapsed;
		logic [13:0] hit_energy_x;
		logic [13:0] hit_energy_y;
	} out_item_t;

	typedef struct packed {
		logic [13:0] energy_x_min;
		logic [13:0] energy_y_min;
		logic [15:0] charge_low;
		logic [15:0] charge_high;
		logic [15:0] ratio_low;
		logic [15:0] ratio_high;
		logic [31:0] min_elapsed;
	} cfg_t;

endpackage

// ===== sv/idpc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// idpc_cfg_regs
// APB-style register bank holding the event gates and the minimum elapsed time.
// ----------------------------------------------------------------------------
module idpc_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [idpc_pkg::ADDR_W-1:0]   paddr,
	input  logic [idpc_pkg::DATA_W-1:0]   pwdata,
	output logic [idpc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output idpc_pkg::cfg_t                cfg
);

	idpc_pkg::cfg_t cfg_q;
	logic [2:0]     reg_idx;
	logic           wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.energy_x_min <= idpc_pkg::RST_ENERGY_X_MIN;
			cfg_q.energy_y_min <= idpc_pkg::RST_ENERGY_Y_MIN;
			cfg_q.charge_low   <= idpc_pkg::RST_CHARGE_LOW;
			cfg_q.charge_high  <= idpc_pkg::RST_CHARGE_HIGH;
			cfg_q.ratio_low    <= idpc_pkg::RST_RATIO_LOW;
			cfg_q.ratio_high   <= idpc_pkg::RST_RATIO_HIGH;
			cfg_q.min_elapsed  <= idpc_pkg::RST_MIN_ELAPSED;
		end else if (wr_en) begin
			case (reg_idx)
				idpc_pkg::REG_ENERGY_X_MIN: cfg_q.energy_x_min <= pwdata[13:0];
				idpc_pkg::REG_ENERGY_Y_MIN: cfg_q.energy_y_min <= pwdata[13:0];
				idpc_pkg::REG_CHARGE_LOW:   cfg_q.charge_low   <= pwdata[15:0];
				idpc_pkg::REG_CHARGE_HIGH:  cfg_q.charge_high  <= pwdata[15:0];
				idpc_pkg::REG_RATIO_LOW:    cfg_q.ratio_low    <= pwdata[15:0];
				idpc_pkg::REG_RATIO_HIGH:   cfg_q.ratio_high   <= pwdata[15:0];
				idpc_pkg::REG_MIN_ELAPSED:  cfg_q.min_elapsed  <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			idpc_pkg::REG_ENERGY_X_MIN: prdata = {18'd0, cfg_q.energy_x_min};
			idpc_pkg::REG_ENERGY_Y_MIN: prdata = {18'd0, cfg_q.energy_y_min};
			idpc_pkg::REG_CHARGE_LOW:   prdata = {16'd0, cfg_q.charge_low};
			idpc_pkg::REG_CHARGE_HIGH:  prdata = {16'd0, cfg_q.charge_high};
			idpc_pkg::REG_RATIO_LOW:    prdata = {16'd0, cfg_q.ratio_low};
			idpc_pkg::REG_RATIO_HIGH:   prdata = {16'd0, cfg_q.ratio_high};
			idpc_pkg::REG_MIN_ELAPSED:  prdata = cfg_q.min_elapsed;
			default:                    prdata = '0;
		endcase
	end

endmodule

// ===== sv/idpc_pixel_ram.sv =====
// ----------------------------------------------------------------------------
// idpc_pixel_ram
// Pixel store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module idpc_pixel_ram #(
	parameter int WIDTH = 98,
	parameter int DEPTH = 98304,
	parameter int AW    = 17
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/implant_decay_pixel_correlator_unit.sv =====
// ----------------------------------------------------------------------------
// implant_decay_pixel_correlator_unit
// Correlates time-ordered implant and decay events per detector pixel.
// ----------------------------------------------------------------------------
// Usage: after reset the block sweeps its pixel store to clear it, one row per
// cycle, and holds busy high until all LAYERS*STRIPS_X*STRIPS_Y rows (98304 at
// the defaults) are cleared; configuration writes are taken during that sweep.
// An item is taken when start is high and busy is low. An item that fails its
// gates or names a pixel outside the array is dropped in its accept cycle, so
// the next item can follow at once. For a gated item the accept cycle reads the
// pixel row from the store, and the following cycle compares times, writes the
// row back and holds busy high. That single read-modify-write of the store
// means no new item is taken until the write-back is done. A correlation
// appears on result, with result_valid high for exactly one cycle, in the
// cycle after the write-back. The receiver cannot stall the block, so every
// strobed result must be captured when it appears.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module implant_decay_pixel_correlator_unit #(
	parameter int LAYERS    = 6,
	parameter int STRIPS_X  = 128,
	parameter int STRIPS_Y  = 128,
	parameter int TIME_BITS = 48
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  idpc_pkg::in_item_t            item,
	output logic                          result_valid,
	output idpc_pkg::out_item_t           result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [idpc_pkg::ADDR_W-1:0]   paddr,
	input  logic [idpc_pkg::DATA_W-1:0]   pwdata,
	output logic [idpc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam int PLANE  = STRIPS_X * STRIPS_Y;
	localparam int PIXELS = LAYERS * PLANE;
	localparam int AW     = (PIXELS > 1) ? $clog2(PIXELS) : 1;
	// Each row holds the implant valid bit and time, then the decay valid bit and time.
	localparam int ROW_W  = 2 * TIME_BITS + 2;
	localparam int CMP_W  = (TIME_BITS > 32) ? TIME_BITS : 32;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE
	} state_t;

	state_t              state_q;
	logic [AW-1:0]       clr_q;
	idpc_pkg::in_item_t  item_s1;
	logic [AW-1:0]       addr_s1;
	logic                result_valid_q;
	idpc_pkg::out_item_t result_q;

	idpc_pkg::cfg_t      cfg;

	// Accept-side signals.
	logic                accept;
	logic                in_range;
	logic                gate_ok;
	logic                take;
	logic [AW-1:0]       pix_addr;

	// Read-modify-write signals.
	logic [ROW_W-1:0]     rd_row;
	logic [ROW_W-1:0]     upd_row;
	logic                 rd_imp_v;
	logic [TIME_BITS-1:0] rd_imp_t;
	logic                 rd_dec_v;
	logic [TIME_BITS-1:0] rd_dec_t;
	logic                 is_decay;
	logic                 then_v;
	logic [TIME_BITS-1:0] then_t;
	logic [TIME_BITS-1:0] now_t;
	logic [TIME_BITS:0]   diff;
	logic                 match;

	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [ROW_W-1:0]     ram_wdata;

	idpc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// The pixel must lie inside the configured array.
	assign in_range = (32'(item.detector) < 32'(LAYERS)) &&
		(32'(item.strip_x) < 32'(STRIPS_X)) &&
		(32'(item.strip_y) < 32'(STRIPS_Y));

	// Implants need the implant quality code and charge and ratio strictly
	// inside their windows; decays need the decay code and both energies above
	// threshold.
	always_comb begin
		if (item.op == idpc_pkg::OP_IMPLANT) begin
			gate_ok = (item.quality == idpc_pkg::IMPLANT_QUALITY) &&
				(item.charge > cfg.charge_low) && (item.charge < cfg.charge_high) &&
				(item.mass_ratio > cfg.ratio_low) && (item.mass_ratio < cfg.ratio_high);
		end else begin
			gate_ok = (item.quality == idpc_pkg::DECAY_QUALITY) &&
				(item.energy_x > cfg.energy_x_min) && (item.energy_y > cfg.energy_y_min);
		end
	end

	assign take     = accept && in_range && gate_ok;
	assign pix_addr = AW'(item.detector) * AW'(PLANE) +
		AW'(item.strip_x) * AW'(STRIPS_Y) + AW'(item.strip_y);

	// Split the row that was read in the accept cycle.
	assign rd_imp_v = rd_row[ROW_W-1];
	assign rd_imp_t = rd_row[ROW_W-2 -: TIME_BITS];
	assign rd_dec_v = rd_row[TIME_BITS];
	assign rd_dec_t = rd_row[TIME_BITS-1:0];

	// A decay looks back at the stored implant, an implant at the stored decay.
	assign is_decay = (item_s1.op == idpc_pkg::OP_DECAY);
	assign then_v   = is_decay ? rd_imp_v : rd_dec_v;
	assign then_t   = is_decay ? rd_imp_t : rd_dec_t;
	assign now_t    = TIME_BITS'(item_s1.timestamp);

	// The borrow bit tells a stored time after the current one; such a
	// time never matches. When there is no borrow the difference is the
	// elapsed tick count, which must exceed the minimum.
	assign diff  = {1'b0, now_t} - {1'b0, then_t};
	assign match = then_v && !diff[TIME_BITS] &&
		(CMP_W'(diff[TIME_BITS-1:0]) > CMP_W'(cfg.min_elapsed));

	// The event records its own time; a match clears the other kind's entry.
	always_comb begin
		if (is_decay) begin
			upd_row = {rd_imp_v & ~match, rd_imp_t, 1'b1, now_t};
		end else begin
			upd_row = {1'b1, now_t, rd_dec_v & ~match, rd_dec_t};
		end
	end

	assign ram_we    = (state_q == ST_CLEAR) || (state_q == ST_UPDATE);
	assign ram_waddr = (state_q == ST_CLEAR) ? clr_q : addr_s1;
	assign ram_wdata = (state_q == ST_CLEAR) ? '0 : upd_row;

	idpc_pixel_ram #(
		.WIDTH (ROW_W),
		.DEPTH (PIXELS),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (take),
		.raddr (pix_addr),
		.rdata (rd_row)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(PIXELS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (take) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					result_valid_q <= match;
					state_q        <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Item and result payload carry no reset.
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item;
			addr_s1 <= pix_addr;
		end
		if (state_q == ST_UPDATE) begin
			result_q.background   <= !is_decay;
			result_q.hit_detector <= item_s1.detector;
			result_q.elapsed      <= 48'(diff[TIME_BITS-1:0]);
			result_q.hit_energy_x <= is_decay ? item_s1.energy_x : '0;
			result_q.hit_energy_y <= is_decay ? item_s1.energy_y : '0;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`ASSERT_IMPLY(a_result_after_update, clk, arst_n, result_valid_q,
		$past(state_q == ST_UPDATE), "result strobe without a preceding write-back")
	`ASSERT_IMPLY(a_no_write_when_idle, clk, arst_n, state_q == ST_IDLE, !ram_we,
		"pixel store written while idle")
	`ASSERT_IMPLY(a_own_valid_set, clk, arst_n, state_q == ST_UPDATE,
		is_decay ? upd_row[TIME_BITS] : upd_row[ROW_W-1],
		"write-back does not mark the event's own time valid")

endmodule
